// File: hw/rtl/hdmsc_pkg.sv
// Shared constants for the hashed direct-mapped sample cache.
package hdmsc_pkg;

  localparam int CAPACITY    = 4096;
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int SAMPLE_BITS = 16;
  localparam int KEY_BITS    = 64;
  localparam int COORD_BITS  = 28;
  localparam int Y_BITS      = 8;
  localparam int HALF_BITS   = KEY_BITS / 2;
  localparam int MIX_SHIFT   = 33;
  localparam int ENTRY_BITS  = KEY_BITS + SAMPLE_BITS;

  localparam logic [SLOT_BITS-1:0] SLOT_MASK = SLOT_BITS'(CAPACITY - 1);
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(CAPACITY - 1);

  localparam logic [KEY_BITS-1:0] MIX_C1 = 64'hFF51AFD7ED558CCD;
  localparam logic [KEY_BITS-1:0] MIX_C2 = 64'hC4CEB9FE1A85EC53;

  localparam logic [KEY_BITS-1:0]    EMPTY_KEY    = '1;
  localparam logic [SAMPLE_BITS-1:0] EMPTY_SAMPLE = '0;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_FILL   = 1'b1;

endpackage

// File: hw/rtl/hashed_direct_mapped_sample_cache.sv
// Direct-mapped sample cache indexed by a murmur3 fmix64 hash of the packed coordinate.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------------------------
//   command  | start / busy      | func, coord_x, coord_y, coord_z, fill_sample
//   result   | done (one cycle)  | hit, stored_sample, was_written
//
// A command transfers when start is high and busy is low. Each command keeps busy
// high through the hash, which runs its two 64-bit products through one shared
// 32x32 multiplier in three steps each, then the table read, then the compare and
// write-back. The result strobe done follows in the next cycle.
// After reset the table is cleared one entry per cycle, with busy high throughout.
// The receiver cannot stall; done lasts exactly one cycle per command.
module hashed_direct_mapped_sample_cache
  import hdmsc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic        [Y_BITS-1:0]      coord_y,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic        [SAMPLE_BITS-1:0] fill_sample,
  output logic                          done,
  output logic                          hit,
  output logic        [SAMPLE_BITS-1:0] stored_sample,
  output logic                          was_written
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;

  localparam logic [1:0] PH_LO_LO = 2'd0;
  localparam logic [1:0] PH_LO_HI = 2'd1;
  localparam logic [1:0] PH_HI_LO = 2'd2;

  logic [2:0]             state;
  logic [1:0]             phase;
  logic                   round;
  logic [SLOT_BITS-1:0]   clr_idx;
  logic [SLOT_BITS-1:0]   slot;
  logic [KEY_BITS-1:0]    key;
  logic [KEY_BITS-1:0]    h;
  logic [KEY_BITS-1:0]    acc;
  logic                   func_r;
  logic [SAMPLE_BITS-1:0] fill_r;

  logic [ENTRY_BITS-1:0]  mem [CAPACITY];
  logic [ENTRY_BITS-1:0]  rd_data;

  logic [KEY_BITS-1:0]    key_in;
  logic [KEY_BITS-1:0]    cst;
  logic [HALF_BITS-1:0]   a_op;
  logic [HALF_BITS-1:0]   b_op;
  logic [KEY_BITS-1:0]    prod;
  logic [HALF_BITS-1:0]   sum_hi;
  logic [KEY_BITS-1:0]    full;
  logic [KEY_BITS-1:0]    mixed;
  logic [KEY_BITS-1:0]    rd_key;
  logic [SAMPLE_BITS-1:0] rd_sample;
  logic                   hit_w;
  logic                   we;
  logic [SLOT_BITS-1:0]   waddr;
  logic [ENTRY_BITS-1:0]  wdata;

  assign busy   = (state != ST_IDLE);
  assign key_in = {coord_y, coord_z, coord_x};

  assign cst    = round ? MIX_C2 : MIX_C1;
  assign a_op   = (phase == PH_HI_LO) ? h[KEY_BITS-1:HALF_BITS] : h[HALF_BITS-1:0];
  assign b_op   = (phase == PH_LO_HI) ? cst[KEY_BITS-1:HALF_BITS] : cst[HALF_BITS-1:0];
  assign prod   = a_op * b_op;
  assign sum_hi = acc[KEY_BITS-1:HALF_BITS] + prod[HALF_BITS-1:0];
  assign full   = {sum_hi, acc[HALF_BITS-1:0]};
  assign mixed  = full ^ (full >> MIX_SHIFT);

  assign rd_key    = rd_data[ENTRY_BITS-1:SAMPLE_BITS];
  assign rd_sample = rd_data[SAMPLE_BITS-1:0];
  assign hit_w     = (rd_key == key);

  always_comb begin
    we    = 1'b0;
    waddr = slot;
    wdata = {key, fill_r};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = {EMPTY_KEY, EMPTY_SAMPLE};
      end
      ST_CMP: begin
        we = (func_r == FUNC_FILL) && !hit_w;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (state == ST_READ) begin
      rd_data <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      phase   <= PH_LO_LO;
      round   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            key    <= key_in;
            h      <= key_in ^ (key_in >> MIX_SHIFT);
            func_r <= func;
            fill_r <= fill_sample;
            phase  <= PH_LO_LO;
            round  <= 1'b0;
            state  <= ST_MUL;
          end
        end
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          case (phase)
            PH_LO_LO: begin
              acc   <= prod;
              phase <= PH_LO_HI;
            end
            PH_LO_HI: begin
              acc   <= full;
              phase <= PH_HI_LO;
            end
            default: begin
              phase <= PH_LO_LO;
              if (round) begin
                slot  <= mixed[SLOT_BITS-1:0] & SLOT_MASK;
                state <= ST_READ;
              end else begin
                h     <= mixed;
                round <= 1'b1;
              end
            end
          endcase
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          done          <= 1'b1;
          hit           <= hit_w;
          stored_sample <= hit_w ? rd_sample : EMPTY_SAMPLE;
          was_written   <= (func_r == FUNC_FILL) && !hit_w;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/hdmsc_checker.sv
// Port-level checks for the hashed direct-mapped sample cache, bound to the top level.
module hdmsc_assertions
  import hdmsc_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          func,
  input logic signed [COORD_BITS-1:0]  coord_x,
  input logic        [Y_BITS-1:0]      coord_y,
  input logic signed [COORD_BITS-1:0]  coord_z,
  input logic        [SAMPLE_BITS-1:0] fill_sample,
  input logic                          done,
  input logic                          hit,
  input logic        [SAMPLE_BITS-1:0] stored_sample,
  input logic                          was_written
);

  a_transfer_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a command transfer");

  a_done_single_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is still in work");

  a_miss_reports_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> stored_sample == '0)
    else $error("miss reported a nonzero sample");

  a_write_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    done && was_written |-> !hit)
    else $error("write reported together with a hit");

endmodule

bind hashed_direct_mapped_sample_cache hdmsc_assertions u_hdmsc_assertions (.*);
